FILE: hdl/ipm_pkg.sv
// Shared types and constants for the inverse perspective pixel map.
package ipm_pkg;

    localparam int CW  = 48;  // coefficient width, Q16.32
    localparam int FW  = 11;  // pixel coordinate field width
    localparam int SW  = 64;  // transform sums at scale 2^33
    localparam int NW  = 66;  // rounded numerator and doubled divisor
    localparam int QW  = 13;  // quotient bits, covers limits up to 8191
    localparam int RW  = NW + QW + 1;  // partial remainder width
    localparam int PW  = CW + FW + 2;  // product width
    localparam int NCOEF = 8;

    localparam logic signed [SW-1:0] HALF_AT_SCALE = SW'(64'sd1 <<< 32);
    localparam logic signed [SW-1:0] ONE_AT_SCALE  = SW'(64'sd1 <<< 33);

    typedef enum logic [3:0] {
        REG_U_X = 4'd0,
        REG_U_Y = 4'd1,
        REG_U_C = 4'd2,
        REG_V_X = 4'd3,
        REG_V_Y = 4'd4,
        REG_V_C = 4'd5,
        REG_W_X = 4'd6,
        REG_W_Y = 4'd7
    } reg_idx_t;

    typedef logic [NCOEF-1:0][CW-1:0] coef_bank_t;

    typedef struct packed {
        logic [FW-1:0] dest_col;
        logic [FW-1:0] dest_row;
    } in_t;

    typedef struct packed {
        logic [FW-1:0] src_col;
        logic [FW-1:0] src_row;
        logic          inside_res;
    } out_t;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [QW-1:0] quo;
        logic          neg;
    } lane_t;

    typedef struct packed {
        lane_t         u;
        lane_t         v;
        logic [NW-1:0] den;
        logic          bad;
    } div_t;

endpackage

FILE: hdl/ipm_front.sv
// Transform evaluation and divider setup: products, sums, magnitudes, range precheck.
module ipm_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_vld,
    input  ipm_pkg::in_t        in_item,
    input  ipm_pkg::coef_bank_t coef,
    output logic                out_vld,
    output ipm_pkg::div_t       out_item
);

    logic [3:0] vld_reg;

    logic signed [ipm_pkg::PW-1:0] p_ux_reg, p_uy_reg, p_vx_reg, p_vy_reg, p_wx_reg, p_wy_reg;
    logic signed [ipm_pkg::SW-1:0] tu_reg, tv_reg, tw_reg;
    logic [ipm_pkg::SW-1:0]        mu_reg, mv_reg, mw_reg;
    logic                          nu_reg, nv_reg, zero_reg;
    ipm_pkg::div_t                 div_reg;

    logic signed [ipm_pkg::FW+1:0] px, py;
    logic [ipm_pkg::NW-1:0]        nnum_u, nnum_v, dden;
    logic [ipm_pkg::RW-1:0]        lim;

    assign px = $signed({1'b0, in_item.dest_col, 1'b1});
    assign py = $signed({1'b0, in_item.dest_row, 1'b1});

    always_comb
    begin
        nnum_u = {1'b0, mu_reg, 1'b0} + ipm_pkg::NW'(mw_reg);
        nnum_v = {1'b0, mv_reg, 1'b0} + ipm_pkg::NW'(mw_reg);
        dden   = {1'b0, mw_reg, 1'b0};
        lim    = ipm_pkg::RW'(dden) << ipm_pkg::QW;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_ux_reg <= $signed(coef[ipm_pkg::REG_U_X]) * px;
            p_uy_reg <= $signed(coef[ipm_pkg::REG_U_Y]) * py;
            p_vx_reg <= $signed(coef[ipm_pkg::REG_V_X]) * px;
            p_vy_reg <= $signed(coef[ipm_pkg::REG_V_Y]) * py;
            p_wx_reg <= $signed(coef[ipm_pkg::REG_W_X]) * px;
            p_wy_reg <= $signed(coef[ipm_pkg::REG_W_Y]) * py;

            tu_reg <= ipm_pkg::SW'(p_ux_reg) + ipm_pkg::SW'(p_uy_reg)
                    + ipm_pkg::SW'($signed({coef[ipm_pkg::REG_U_C], 1'b0}))
                    - ipm_pkg::HALF_AT_SCALE;
            tv_reg <= ipm_pkg::SW'(p_vx_reg) + ipm_pkg::SW'(p_vy_reg)
                    + ipm_pkg::SW'($signed({coef[ipm_pkg::REG_V_C], 1'b0}))
                    - ipm_pkg::HALF_AT_SCALE;
            tw_reg <= ipm_pkg::SW'(p_wx_reg) + ipm_pkg::SW'(p_wy_reg)
                    + ipm_pkg::ONE_AT_SCALE;

            mu_reg   <= tu_reg[ipm_pkg::SW-1] ? ipm_pkg::SW'(-tu_reg) : tu_reg;
            mv_reg   <= tv_reg[ipm_pkg::SW-1] ? ipm_pkg::SW'(-tv_reg) : tv_reg;
            mw_reg   <= tw_reg[ipm_pkg::SW-1] ? ipm_pkg::SW'(-tw_reg) : tw_reg;
            nu_reg   <= tu_reg[ipm_pkg::SW-1] ^ tw_reg[ipm_pkg::SW-1];
            nv_reg   <= tv_reg[ipm_pkg::SW-1] ^ tw_reg[ipm_pkg::SW-1];
            zero_reg <= (tw_reg == '0);

            // A quotient that needs more than QW bits lies outside any image.
            div_reg.u.rem <= ipm_pkg::RW'(nnum_u);
            div_reg.u.quo <= '0;
            div_reg.u.neg <= nu_reg;
            div_reg.v.rem <= ipm_pkg::RW'(nnum_v);
            div_reg.v.quo <= '0;
            div_reg.v.neg <= nv_reg;
            div_reg.den   <= dden;
            div_reg.bad   <= zero_reg || (ipm_pkg::RW'(nnum_u) >= lim)
                          || (ipm_pkg::RW'(nnum_v) >= lim);
        end
    end

    assign out_vld  = vld_reg[3];
    assign out_item = div_reg;

endmodule

FILE: hdl/ipm_div_cell.sv
// One restoring division cell: settles one quotient bit for both coordinates.
module ipm_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_vld,
    input  ipm_pkg::div_t in_item,
    output logic          out_vld,
    output ipm_pkg::div_t out_item
);

    logic                   vld_reg;
    ipm_pkg::div_t          item_reg;
    ipm_pkg::div_t          item_next;
    logic [ipm_pkg::RW-1:0] trial;
    logic                   ge_u, ge_v;

    always_comb
    begin
        trial     = ipm_pkg::RW'(in_item.den) << SHIFT;
        ge_u      = in_item.u.rem >= trial;
        ge_v      = in_item.v.rem >= trial;
        item_next = in_item;
        if (ge_u)
        begin
            item_next.u.rem = in_item.u.rem - trial;
        end
        if (ge_v)
        begin
            item_next.v.rem = in_item.v.rem - trial;
        end
        item_next.u.quo = in_item.u.quo | (ipm_pkg::QW'(ge_u) << SHIFT);
        item_next.v.quo = in_item.v.quo | (ipm_pkg::QW'(ge_v) << SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_item = item_reg;

endmodule

FILE: hdl/inverse_perspective_pixel_map.sv
// Top level of the inverse perspective pixel map: config registers, pipeline, output stage.
//
// Each input transaction carries one destination pixel (dest_col, dest_row). The block
// evaluates the inverse projective transform held in eight Q16.32 coefficient registers,
// divides by the homogeneous term with rounding half away from zero, and returns one
// output transaction with the source pixel and an inside flag (zero coordinates when
// outside, including a zero divisor).
// Coefficients are written through cfg_we/cfg_index/cfg_data, one register per cycle, by
// the user only while no transaction is in flight; the block does not enforce this. Indexes
// beyond the last register are ignored. Products, sums, magnitudes and divider setup are
// registered in turn, then 13 division cells settle one quotient bit each before the output
// register. Throughput is one pixel per cycle unless out_ready stalls; every stage advances
// together. When the receiver holds out_ready low with a result waiting, the whole pipeline
// freezes and in_ready drops in the same cycle; nothing is lost or repeated. Reset clears
// all valid flags and loads the identity map into the coefficients.
module inverse_perspective_pixel_map #(
    parameter int IMG_WIDTH  = 2048,
    parameter int IMG_HEIGHT = 2048
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [3:0]             cfg_index,
    input  logic [ipm_pkg::CW-1:0] cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  ipm_pkg::in_t           in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output ipm_pkg::out_t          out_data
);

    localparam logic [ipm_pkg::QW-1:0] LIM_U = ipm_pkg::QW'(IMG_WIDTH);
    localparam logic [ipm_pkg::QW-1:0] LIM_V = ipm_pkg::QW'(IMG_HEIGHT);

    // Identity map: 1.0 in the u-per-x and v-per-y coefficients.
    localparam ipm_pkg::coef_bank_t COEF_RESET =
        (ipm_pkg::coef_bank_t'(1) << (ipm_pkg::CW * int'(ipm_pkg::REG_U_X) + 32))
      | (ipm_pkg::coef_bank_t'(1) << (ipm_pkg::CW * int'(ipm_pkg::REG_V_Y) + 32));

    ipm_pkg::coef_bank_t coef_reg;
    logic                en;
    logic                out_valid_reg;
    ipm_pkg::out_t       out_data_reg;
    ipm_pkg::out_t       out_data_next;
    logic                ok_u, ok_v, pix_inside;

    logic                chain_vld  [ipm_pkg::QW+1];
    ipm_pkg::div_t       chain_item [ipm_pkg::QW+1];

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= COEF_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ipm_pkg::REG_U_X: coef_reg[ipm_pkg::REG_U_X] <= cfg_data;
                ipm_pkg::REG_U_Y: coef_reg[ipm_pkg::REG_U_Y] <= cfg_data;
                ipm_pkg::REG_U_C: coef_reg[ipm_pkg::REG_U_C] <= cfg_data;
                ipm_pkg::REG_V_X: coef_reg[ipm_pkg::REG_V_X] <= cfg_data;
                ipm_pkg::REG_V_Y: coef_reg[ipm_pkg::REG_V_Y] <= cfg_data;
                ipm_pkg::REG_V_C: coef_reg[ipm_pkg::REG_V_C] <= cfg_data;
                ipm_pkg::REG_W_X: coef_reg[ipm_pkg::REG_W_X] <= cfg_data;
                ipm_pkg::REG_W_Y: coef_reg[ipm_pkg::REG_W_Y] <= cfg_data;
                default: ;
            endcase
        end
    end

    ipm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (in_valid),
        .in_item  (in_data),
        .coef     (coef_reg),
        .out_vld  (chain_vld[0]),
        .out_item (chain_item[0])
    );

    for (genvar i = 0; i < ipm_pkg::QW; i++)
    begin : g_cell
        ipm_div_cell #(
            .SHIFT (ipm_pkg::QW - 1 - i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (chain_vld[i]),
            .in_item  (chain_item[i]),
            .out_vld  (chain_vld[i+1]),
            .out_item (chain_item[i+1])
        );
    end

    always_comb
    begin
        // A negative quotient is acceptable only when it rounds to zero.
        ok_u = (!chain_item[ipm_pkg::QW].u.neg || chain_item[ipm_pkg::QW].u.quo == '0)
            && (chain_item[ipm_pkg::QW].u.quo < LIM_U);
        ok_v = (!chain_item[ipm_pkg::QW].v.neg || chain_item[ipm_pkg::QW].v.quo == '0)
            && (chain_item[ipm_pkg::QW].v.quo < LIM_V);
        pix_inside = !chain_item[ipm_pkg::QW].bad && ok_u && ok_v;
        out_data_next.inside_res = pix_inside;
        out_data_next.src_col    = pix_inside
                                 ? chain_item[ipm_pkg::QW].u.quo[ipm_pkg::FW-1:0] : '0;
        out_data_next.src_row    = pix_inside
                                 ? chain_item[ipm_pkg::QW].v.quo[ipm_pkg::FW-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= chain_vld[ipm_pkg::QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.inside_res |-> out_data.src_col == '0 && out_data.src_row == '0)
        else $error("outside result carries nonzero coordinates");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while the output is stalled");

    a_cell_bound: assert property (@(posedge clk) disable iff (!rst_n)
        chain_vld[ipm_pkg::QW] && !chain_item[ipm_pkg::QW].bad
        |-> chain_item[ipm_pkg::QW].u.rem < ipm_pkg::RW'(chain_item[ipm_pkg::QW].den))
        else $error("division remainder not below divisor");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");
`endif

endmodule

FILE: tb/inverse_perspective_pixel_map_tb.sv
// Self-checking testbench for the inverse perspective pixel map.
module inverse_perspective_pixel_map_tb;

    localparam int  LATENCY     = 18;
    localparam int  CYCLE_LIMIT = 400000;
    localparam logic [3:0] IDX_SPARE_LO = 4'd8;
    localparam logic [3:0] IDX_SPARE_HI = 4'd15;
    localparam longint ONE_Q = 64'sd1 <<< 32;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [3:0]             cfg_index;
    logic [ipm_pkg::CW-1:0] cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    ipm_pkg::in_t           in_data;
    logic                   out_valid;
    logic                   out_ready;
    ipm_pkg::out_t          out_data;

    logic [ipm_pkg::CW-1:0] coef_copy [ipm_pkg::NCOEF];
    ipm_pkg::out_t          pixel_expect_q [$];
    int                     fail_count;
    int                     cycle_count;
    int                     stall_hold;
    int                     ready_gap;

    inverse_perspective_pixel_map u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #1 clk = ~clk;

    function automatic longint sx(logic [ipm_pkg::CW-1:0] raw);
        return longint'($signed(raw));
    endfunction

    // Rounds num/den half away from zero; true when the result lies in [0, lim).
    function automatic bit round_to_pixel(longint num, longint den, int lim,
                                          output logic [ipm_pkg::FW-1:0] pix);
        logic [65:0] n;
        logic [65:0] d;
        logic [65:0] q;
        bit          neg;
        n   = 66'(num < 0 ? -num : num);
        d   = 66'(den < 0 ? -den : den);
        neg = (num < 0) != (den < 0);
        q   = (2 * n + d) / (2 * d);
        pix = '0;
        if (neg && q != 0)
            return 0;
        if (q >= lim)
            return 0;
        pix = q[ipm_pkg::FW-1:0];
        return 1;
    endfunction

    function automatic ipm_pkg::out_t map_pixel(ipm_pkg::in_t p);
        longint        px;
        longint        py;
        longint        tu;
        longint        tv;
        longint        tw;
        ipm_pkg::out_t r;
        bit            ok;
        px = 2 * longint'(p.dest_col) + 1;
        py = 2 * longint'(p.dest_row) + 1;
        tu = sx(coef_copy[ipm_pkg::REG_U_X]) * px + sx(coef_copy[ipm_pkg::REG_U_Y]) * py
           + 2 * sx(coef_copy[ipm_pkg::REG_U_C]) - longint'(ipm_pkg::HALF_AT_SCALE);
        tv = sx(coef_copy[ipm_pkg::REG_V_X]) * px + sx(coef_copy[ipm_pkg::REG_V_Y]) * py
           + 2 * sx(coef_copy[ipm_pkg::REG_V_C]) - longint'(ipm_pkg::HALF_AT_SCALE);
        tw = sx(coef_copy[ipm_pkg::REG_W_X]) * px + sx(coef_copy[ipm_pkg::REG_W_Y]) * py
           + longint'(ipm_pkg::ONE_AT_SCALE);
        r = '0;
        ok = 0;
        if (tw != 0)
        begin
            ok = round_to_pixel(tu, tw, 2048, r.src_col);
            if (ok)
                ok = round_to_pixel(tv, tw, 2048, r.src_row);
        end
        if (!ok)
        begin
            r.src_col = '0;
            r.src_row = '0;
        end
        r.inside_res = ok;
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 12)
            return 0;
        if (roll < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Record accepted pixels and predict their source mapping.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            pixel_expect_q.push_back(map_pixel(in_data));
    end

    always @(posedge clk)
    begin
        ipm_pkg::out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pixel_expect_q.size() == 0)
            begin
                $display("%0t: unexpected output transaction %h", $time, out_data);
                fail_count++;
            end
            else
            begin
                want = pixel_expect_q.pop_front();
                if (out_data.src_col !== want.src_col)
                begin
                    $display("%0t: src_col expected %0d actual %0d",
                             $time, want.src_col, out_data.src_col);
                    fail_count++;
                end
                if (out_data.src_row !== want.src_row)
                begin
                    $display("%0t: src_row expected %0d actual %0d",
                             $time, want.src_row, out_data.src_row);
                    fail_count++;
                end
                if (out_data.inside_res !== want.inside_res)
                begin
                    $display("%0t: inside_res expected %0b actual %0b",
                             $time, want.inside_res, out_data.inside_res);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: random stalls of random length, plus a long hold-off when one is requested.
    always @(negedge clk)
    begin
        int gap;
        if (stall_hold > 0)
        begin
            out_ready <= 1'b0;
            stall_hold <= stall_hold - 1;
        end
        else if (ready_gap > 0)
        begin
            out_ready <= 1'b0;
            ready_gap <= ready_gap - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            gap = pick_gap();
            out_ready <= (gap == 0);
            ready_gap <= (gap > 0) ? gap - 1 : 0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("inverse_perspective_pixel_map test failed");
            $finish;
        end
    end

    task automatic cfg_write(logic [3:0] idx, logic [ipm_pkg::CW-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        if (idx < ipm_pkg::NCOEF)
            coef_copy[idx] = val;
        @(posedge clk);
    endtask

    task automatic cfg_done();
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_map(longint ux, longint uy, longint uc, longint vx,
                            longint vy, longint vc, longint wx, longint wy);
        cfg_write(ipm_pkg::REG_U_X, ipm_pkg::CW'(ux));
        cfg_write(ipm_pkg::REG_U_Y, ipm_pkg::CW'(uy));
        cfg_write(ipm_pkg::REG_U_C, ipm_pkg::CW'(uc));
        cfg_write(ipm_pkg::REG_V_X, ipm_pkg::CW'(vx));
        cfg_write(ipm_pkg::REG_V_Y, ipm_pkg::CW'(vy));
        cfg_write(ipm_pkg::REG_V_C, ipm_pkg::CW'(vc));
        cfg_write(ipm_pkg::REG_W_X, ipm_pkg::CW'(wx));
        cfg_write(ipm_pkg::REG_W_Y, ipm_pkg::CW'(wy));
        cfg_done();
    endtask

    // Called with the clock just past a falling edge; leaves it the same way.
    task automatic send_pixel(int col, int row, bit no_gap = 0);
        int gap;
        in_data.dest_col = ipm_pkg::FW'(col);
        in_data.dest_row = ipm_pkg::FW'(row);
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Called just past a falling edge, after the last transaction was accepted.
    task automatic drain();
        in_valid = 1'b0;
        while (pixel_expect_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(int count);
        repeat (count)
            send_pixel($urandom_range(0, 2047), $urandom_range(0, 2047));
    endtask

    function automatic longint rand_span(longint span);
        longint r;
        r = longint'({$urandom, $urandom});
        r = r % (2 * span + 1);
        if (r < 0)
            r = -r;
        return r - span;
    endfunction

    function automatic longint rand_full();
        return sx(ipm_pkg::CW'({$urandom, $urandom}));
    endfunction

    task automatic test_identity();
        @(negedge clk);
        send_pixel(0, 0);
        send_pixel(2047, 2047);
        send_pixel(0, 2047);
        send_pixel(2047, 0);
        send_pixel(1024, 5);
        send_pixel(1365, 682);
        drain();
    endtask

    // Shifted and scaled maps push results past the top edge and below zero.
    task automatic test_rounding_halves();
        load_map(ONE_Q, 0, ONE_Q, 0, ONE_Q, -ONE_Q, 0, 0);
        send_pixel(0, 5);
        send_pixel(2047, 5);
        send_pixel(2046, 0);
        send_pixel(100, 1);
        drain();
        load_map(ONE_Q / 2, 0, 0, 0, -ONE_Q, 2047 * ONE_Q, 0, 0);
        send_pixel(1, 0);
        send_pixel(3, 2047);
        send_pixel(2047, 1);
        drain();
    endtask

    task automatic test_zero_divisor();
        load_map(ONE_Q, 0, 0, 0, ONE_Q, 0, -2 * ONE_Q, 0);
        send_pixel(0, 7);
        send_pixel(1, 7);
        send_pixel(2047, 0);
        drain();
        load_map(ONE_Q, ONE_Q, 0, 0, ONE_Q, 0, ONE_Q / 2, -ONE_Q / 2);
        send_pixel(10, 8);
        send_pixel(10, 10);
        drain();
    endtask

    task automatic test_extreme_coefs();
        longint hi;
        longint lo;
        hi = (64'sd1 <<< 47) - 1;
        lo = -(64'sd1 <<< 47);
        load_map(hi, hi, hi, lo, lo, lo, hi, lo);
        send_pixel(0, 0);
        send_pixel(2047, 2047);
        drain();
        load_map(lo, lo, lo, hi, hi, hi, lo, hi);
        send_pixel(2047, 0);
        send_pixel(0, 2047);
        drain();
    endtask

    // Writes to spare indexes must leave the coefficient bank untouched.
    task automatic test_spare_index();
        load_map(ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0);
        cfg_write(IDX_SPARE_LO, ipm_pkg::CW'(rand_full()));
        cfg_write(IDX_SPARE_HI, ipm_pkg::CW'(rand_full()));
        cfg_done();
        send_pixel(300, 400);
        send_pixel(2047, 1);
        drain();
    endtask

    // Maps with scales in +-2, moderate offsets, small w terms; then one fully random map.
    task automatic test_random_maps();
        repeat (8)
        begin
            load_map(rand_span(2 * ONE_Q), rand_span(ONE_Q / 2), rand_span(1024 * ONE_Q),
                     rand_span(ONE_Q / 2), rand_span(2 * ONE_Q), rand_span(1024 * ONE_Q),
                     rand_span(64'sd1 <<< 22), rand_span(64'sd1 <<< 22));
            send_random(45);
            drain();
        end
        load_map(rand_full(), rand_full(), rand_full(), rand_full(),
                 rand_full(), rand_full(), rand_full(), rand_full());
        send_random(30);
        drain();
    endtask

    task automatic test_backpressure();
        load_map(ONE_Q, rand_span(ONE_Q / 4), rand_span(64 * ONE_Q),
                 rand_span(ONE_Q / 4), ONE_Q, rand_span(64 * ONE_Q),
                 rand_span(64'sd1 <<< 20), rand_span(64'sd1 <<< 20));
        stall_hold = 120;
        repeat (60)
            send_pixel($urandom_range(0, 2047), $urandom_range(0, 2047), 1);
        drain();
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = ipm_pkg::REG_U_X;
        cfg_data    = '0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b0;
        fail_count  = 0;
        cycle_count = 0;
        stall_hold  = 0;
        ready_gap   = 0;
        foreach (coef_copy[i])
            coef_copy[i] = '0;
        coef_copy[ipm_pkg::REG_U_X] = ipm_pkg::CW'(ONE_Q);
        coef_copy[ipm_pkg::REG_V_Y] = ipm_pkg::CW'(ONE_Q);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_identity();
        test_rounding_halves();
        test_zero_divisor();
        test_extreme_coefs();
        test_spare_index();
        test_random_maps();
        test_backpressure();

        if (fail_count == 0 && pixel_expect_q.size() == 0)
            $display("inverse_perspective_pixel_map test passed");
        else
            $display("inverse_perspective_pixel_map test failed");
        $finish;
    end

endmodule

FILE: inverse_perspective_pixel_map.f
hdl/ipm_pkg.sv
hdl/ipm_front.sv
hdl/ipm_div_cell.sv
hdl/inverse_perspective_pixel_map.sv
tb/inverse_perspective_pixel_map_tb.sv
